[hdl/bpam_pkg.sv]
// shared types and constants of the block peak average meter
`default_nettype none
package bpam_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned TICK_W = 17;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned INPUT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd15000;

  // one quotient bit per step
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic REG_INTERVAL = 1'b0;

  typedef struct packed {
    logic take;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic report_hit;
  } status_t;

endpackage
`default_nettype wire

[hdl/bpam_divider.sv]
// restoring divider, one quotient bit per cycle while step is high
`default_nettype none
module bpam_divider (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [bpam_pkg::SUM_W-1:0]   dividend,
  input  wire logic [bpam_pkg::COUNT_W-1:0] divisor,
  output logic      [bpam_pkg::SUM_W-1:0]   quotient
);

  logic [bpam_pkg::COUNT_W-1:0] rem;
  logic [bpam_pkg::COUNT_W-1:0] dvs;
  logic [bpam_pkg::COUNT_W:0]   rem_sh;
  logic [bpam_pkg::COUNT_W:0]   rem_sub;
  logic                         fits;

  always_comb begin
    rem_sh  = {rem, quotient[bpam_pkg::SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (step) begin
      quotient <= {quotient[bpam_pkg::SUM_W-2:0], fits};
      // remainder stays below the divisor, so the low bits suffice
      rem      <= fits ? rem_sub[bpam_pkg::COUNT_W-1:0] : rem_sh[bpam_pkg::COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hdl/bpam_datapath.sv]
// peak tracking, accumulation, timer and result registers
`default_nettype none
module bpam_datapath #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            operation,
  input  wire logic signed [bpam_pkg::INPUT_W-1:0] sample_value,
  input  wire logic                            block_end,
  input  wire logic [bpam_pkg::INTERVAL_W-1:0] interval,
  input  wire bpam_pkg::cmd_t                  cmd,
  output bpam_pkg::status_t                    status,
  output logic [bpam_pkg::LEVEL_W-1:0]         average_level,
  output logic [bpam_pkg::COUNT_W-1:0]         blocks_averaged
);

  logic [SAMPLE_BITS-1:0]         raw;
  logic [SAMPLE_BITS-1:0]         mag_full;
  logic [bpam_pkg::LEVEL_W-1:0]   mag;
  logic [bpam_pkg::LEVEL_W-1:0]   peak_upd;
  logic [bpam_pkg::SUM_W:0]       sum_wide;
  logic [bpam_pkg::SUM_W-1:0]     sum_upd;
  logic [bpam_pkg::COUNT_W-1:0]   count_upd;
  logic [bpam_pkg::TICK_W-1:0]    elapsed_eff;

  logic [bpam_pkg::LEVEL_W-1:0]   block_peak;
  logic [bpam_pkg::SUM_W-1:0]     peak_sum;
  logic [bpam_pkg::COUNT_W-1:0]   block_count;
  logic [bpam_pkg::TICK_W-1:0]    elapsed_ticks;
  logic                           timing_started;
  logic [bpam_pkg::COUNT_W-1:0]   report_count;
  logic [bpam_pkg::SUM_W-1:0]     quotient;
  logic                           div_load;

  always_comb begin
    raw      = SAMPLE_BITS'($unsigned(sample_value));
    // most negative code maps onto itself, read as unsigned
    mag_full = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    mag      = bpam_pkg::LEVEL_W'(mag_full);
    peak_upd = (mag > block_peak) ? mag : block_peak;

    sum_wide = {1'b0, peak_sum} + {{(bpam_pkg::SUM_W + 1 - bpam_pkg::LEVEL_W){1'b0}}, peak_upd};
    if (block_count == bpam_pkg::COUNT_MAX) begin
      sum_upd   = peak_sum;
      count_upd = block_count;
    end else begin
      sum_upd   = sum_wide[bpam_pkg::SUM_W] ? bpam_pkg::SUM_MAX : sum_wide[bpam_pkg::SUM_W-1:0];
      count_upd = block_count + 1'b1;
    end

    elapsed_eff = timing_started ? elapsed_ticks : '0;
    status.report_hit = (operation == bpam_pkg::OP_SAMPLE) && block_end &&
                        (elapsed_eff > {1'b0, interval});
    div_load = cmd.take && status.report_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_peak     <= '0;
      peak_sum       <= '0;
      block_count    <= '0;
      elapsed_ticks  <= '0;
      timing_started <= 1'b0;
    end else if (cmd.take) begin
      if (operation == bpam_pkg::OP_TICK) begin
        if (timing_started && elapsed_ticks != bpam_pkg::TICK_MAX) begin
          elapsed_ticks <= elapsed_ticks + 1'b1;
        end
      end else if (!block_end) begin
        block_peak <= peak_upd;
      end else begin
        block_peak     <= '0;
        timing_started <= 1'b1;
        if (status.report_hit) begin
          peak_sum      <= '0;
          block_count   <= '0;
          elapsed_ticks <= '0;
        end else begin
          peak_sum      <= sum_upd;
          block_count   <= count_upd;
          elapsed_ticks <= elapsed_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      report_count <= count_upd;
    end
    if (cmd.out_load) begin
      average_level   <= (quotient[bpam_pkg::SUM_W-1:bpam_pkg::LEVEL_W] != '0) ?
                         '1 : quotient[bpam_pkg::LEVEL_W-1:0];
      blocks_averaged <= report_count;
    end
  end

  bpam_divider u_divider (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .dividend (sum_upd),
    .divisor  (count_upd),
    .quotient (quotient)
  );

endmodule
`default_nettype wire

[hdl/bpam_ctrl.sv]
// sequencer: item intake, division steps and result hand-off
`default_nettype none
module bpam_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire bpam_pkg::status_t status,
  output bpam_pkg::cmd_t         cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    DELIVER
  } state_t;

  state_t                      state;
  logic [bpam_pkg::STEP_W-1:0] step_cnt;

  always_comb begin
    in_stall     = (state != IDLE);
    cmd.take     = (state == IDLE) && in_valid;
    cmd.div_step = (state == DIVIDE);
    cmd.out_load = (state == DELIVER) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          step_cnt <= '0;
          if (cmd.take && status.report_hit) begin
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == bpam_pkg::STEP_W'(bpam_pkg::DIV_STEPS - 1)) begin
            state <= DELIVER;
          end
        end
        DELIVER: begin
          if (cmd.out_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/block_peak_average_meter_core.sv]
// top level of the block peak average meter: register port, sequencer and datapath
//
//  channel  direction  handshake            word
//  in       sink       in_valid/in_stall    operation, sample_value, block_end
//  out      source     out_valid/out_stall  average_level, blocks_averaged
//  config   apb slave  psel/penable/pready  report_interval_ticks at 0x0
//
// a tick or a sample that closes no interval leaves in_stall low, so the next word can follow
// a word that closes an interval goes through intake, 32 steps of the
//   restoring divider (one quotient bit per cycle) and the hand-off
// rst is synchronous, clears all accumulators and sets the interval to 15000
// in_stall is high while the divider runs or the result waits for the output
// the output register holds a result while out_stall is high; new words
//   are still taken once the result has been handed to it
`default_nettype none
module block_peak_average_meter_core #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input words
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 operation,
  input  wire logic signed [bpam_pkg::INPUT_W-1:0]  sample_value,
  input  wire logic                                 block_end,
  // result words
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [bpam_pkg::LEVEL_W-1:0]              average_level,
  output logic [bpam_pkg::COUNT_W-1:0]              blocks_averaged,
  // register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  bpam_pkg::cmd_t                  cmd;
  bpam_pkg::status_t               status;
  logic [bpam_pkg::INTERVAL_W-1:0] report_interval_ticks;
  logic                            reg_hit;

  // word address: bit 2 picks the register, low bits are byte lanes
  always_comb begin
    pready  = 1'b1;
    reg_hit = (paddr[2] == bpam_pkg::REG_INTERVAL);
    prdata  = reg_hit ? {{(32 - bpam_pkg::INTERVAL_W){1'b0}}, report_interval_ticks} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval_ticks <= bpam_pkg::INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      report_interval_ticks <= pwdata[bpam_pkg::INTERVAL_W-1:0];
    end
  end

  // sequencer owns the handshakes and the division step count
  bpam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // peak, sum, count, timer, divider and result registers
  bpam_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .operation       (operation),
    .sample_value    (sample_value),
    .block_end       (block_end),
    .interval        (report_interval_ticks),
    .cmd             (cmd),
    .status          (status),
    .average_level   (average_level),
    .blocks_averaged (blocks_averaged)
  );

endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the block peak average meter: directed table, then random blocks
`default_nettype none
module tb_top;

  // cycle budget, with room for every word closing an interval under full stalls
  localparam int unsigned CYCLE_LIMIT = 200000;
  // settle long enough for a word that closes an interval to finish
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RAND_WORDS = 725;
  localparam logic [2:0] ADDR_INTERVAL = 3'(4 * bpam_pkg::REG_INTERVAL);

  typedef struct packed {
    logic [bpam_pkg::LEVEL_W-1:0] level;
    logic [bpam_pkg::COUNT_W-1:0] blocks;
  } level_report_t;

  // directed table rows: a word repeated reps times, or an interval write
  typedef enum logic {ROW_WORD, ROW_SET_INTERVAL} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic op;
    logic [15:0] value;     // sample for a word, register value for a write
    logic blk_end;
    logic [17:0] reps;
    logic typed;            // expectation typed into the row, not predicted
    logic exp_hit;
    level_report_t exp_rep;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = bpam_pkg::OP_SAMPLE;
  logic signed [bpam_pkg::INPUT_W-1:0] sample_value = '0;
  logic block_end = 1'b0;

  // output channel
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bpam_pkg::LEVEL_W-1:0] average_level;
  logic [bpam_pkg::COUNT_W-1:0] blocks_averaged;

  // register port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state, mirrors the block's accumulators
  logic [bpam_pkg::INTERVAL_W-1:0] mtr_interval = bpam_pkg::INTERVAL_RESET;
  logic [bpam_pkg::LEVEL_W-1:0] mtr_peak = '0;
  logic [bpam_pkg::SUM_W-1:0] mtr_sum = '0;
  logic [bpam_pkg::COUNT_W-1:0] mtr_count = '0;
  logic [bpam_pkg::TICK_W-1:0] mtr_ticks = '0;
  logic mtr_timing = 1'b0;

  // averages predicted but not yet seen on the output
  level_report_t pending_averages[$];
  stim_row_t stim_rows[$];

  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  int unsigned n_words = 0;
  int unsigned n_averages_expected = 0;
  int unsigned n_averages_checked = 0;
  int unsigned n_settings = 1;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit stall_drawn = 1'b0;
  int unsigned stall_left = 0;

  block_peak_average_meter_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .sample_value(sample_value),
    .block_end(block_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average_level(average_level),
    .blocks_averaged(blocks_averaged),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at cycle %0d: %s", n_cycles, msg);
    n_errors++;
  endtask

  // advance the meter by one word; returns 1 when the word closes an interval
  function automatic logic predict_average(input logic op, input logic [15:0] smp,
                                           input logic blk_end, output level_report_t rep);
    logic [16:0] mag;
    logic [bpam_pkg::SUM_W:0] wide_sum;
    logic [bpam_pkg::SUM_W-1:0] quot;
    rep = '0;
    // ticks only count once the first block has closed, and saturate
    if (op == bpam_pkg::OP_TICK) begin
      if (mtr_timing && mtr_ticks != bpam_pkg::TICK_MAX) mtr_ticks++;
      return 1'b0;
    end
    // magnitude of a 16-bit two's complement sample, -32768 gives 32768
    mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
    if (mag > {1'b0, mtr_peak}) mtr_peak = mag[15:0];
    if (!blk_end) return 1'b0;
    // a full block count freezes the sum and the count
    if (mtr_count != bpam_pkg::COUNT_MAX) begin
      wide_sum = {1'b0, mtr_sum} + mtr_peak;
      mtr_sum = wide_sum[bpam_pkg::SUM_W] ? bpam_pkg::SUM_MAX : wide_sum[bpam_pkg::SUM_W-1:0];
      mtr_count++;
    end
    mtr_peak = '0;
    if (!mtr_timing) begin
      mtr_timing = 1'b1;
      mtr_ticks = '0;
    end
    // the interval must be strictly exceeded
    if (mtr_ticks <= {1'b0, mtr_interval}) return 1'b0;
    quot = mtr_sum / {{(bpam_pkg::SUM_W-bpam_pkg::COUNT_W){1'b0}}, mtr_count};
    rep.level = (quot > 32'hFFFF) ? '1 : quot[bpam_pkg::LEVEL_W-1:0];
    rep.blocks = mtr_count;
    mtr_sum = '0;
    mtr_count = '0;
    mtr_ticks = '0;
    return 1'b1;
  endfunction

  // drive one word, wait for it to be taken, then record what it should produce
  task automatic send_word(input logic op, input logic [15:0] smp, input logic blk_end,
                           input bit quick, input logic typed, input logic typed_hit,
                           input level_report_t typed_rep);
    int unsigned gap;
    logic hit;
    level_report_t rep;
    gap = (quick || in_burst) ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    sample_value <= smp;
    block_end <= blk_end;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n_words++;
    hit = predict_average(op, smp, blk_end, rep);
    if (typed) begin
      hit = typed_hit;
      rep = typed_rep;
    end
    if (hit) begin
      pending_averages.push_back(rep);
      n_averages_expected++;
    end
  endtask

  // stop sending, let every pending average come out and the block go quiet
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    // setup phase, then access phase, completed when pready is seen
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_INTERVAL;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_interval_reg();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[bpam_pkg::INTERVAL_W-1:0] !== mtr_interval)
      report_mismatch($sformatf("interval reads %0d, expected %0d",
                                rd[bpam_pkg::INTERVAL_W-1:0], mtr_interval));
  endtask

  // upper data bits are random, only the low 16 belong to the register
  task automatic set_interval(input logic [bpam_pkg::INTERVAL_W-1:0] value);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, {16'($urandom), value}, rd);
    mtr_interval = value;
    n_settings++;
    check_interval_reg();
  endtask

  task automatic add_row(input row_kind_t kind, input logic op, input logic [15:0] value,
                         input logic blk_end, input int unsigned reps, input logic typed,
                         input logic hit, input logic [15:0] lvl, input logic [15:0] cnt);
    stim_row_t row;
    row.kind = kind;
    row.op = op;
    row.value = value;
    row.blk_end = blk_end;
    row.reps = 18'(reps);
    row.typed = typed;
    row.exp_hit = hit;
    row.exp_rep.level = lvl;
    row.exp_rep.blocks = cnt;
    stim_rows.push_back(row);
  endtask

  // output side: each result may be stalled at random, with occasional runs of no stall;
  // while nothing is offered, stall toggles at random
  always @(negedge clk) begin : result_stall
    if (out_valid === 1'b1 && !stall_drawn) begin
      stall_left = out_burst ? 0 : $urandom_range(0, 4);
      stall_drawn = 1'b1;
    end
    if (out_valid !== 1'b1) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest predicted average
  always @(posedge clk) begin : result_check
    level_report_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("unexpected average level=%0d blocks=%0d",
                                  average_level, blocks_averaged));
      end else begin
        want = pending_averages.pop_front();
        n_averages_checked++;
        if (average_level !== want.level)
          report_mismatch($sformatf("average_level %0d, expected %0d",
                                    average_level, want.level));
        if (blocks_averaged !== want.blocks)
          report_mismatch($sformatf("blocks_averaged %0d, expected %0d",
                                    blocks_averaged, want.blocks));
      end
      stall_drawn = 1'b0;
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
    end
  end

  // run watchdog
  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_top: timed out after %0d cycles, %0d averages still pending",
               n_cycles, pending_averages.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    level_report_t no_rep;
    logic [bpam_pkg::INTERVAL_W-1:0] iv;
    int unsigned n_rand;
    int phase_left;
    int unsigned blk_len;
    logic [15:0] smp;

    no_rep = '0;

    // directed table, interval starts at its reset value of 15000
    // ticks before the first block closes are ignored; ignored fields carry junk
    add_row(ROW_WORD, bpam_pkg::OP_TICK, 16'h5A5A, 1'b1, 3, 1'b1, 1'b0, 16'd0, 16'd0);
    // both extremes in one block, peak is 32768, the timer starts here
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h7FFF, 1'b0, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h8000, 1'b1, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    // short interval: exactly the interval is not enough
    add_row(ROW_SET_INTERVAL, bpam_pkg::OP_SAMPLE, 16'd4, 1'b0, 1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_TICK, 16'h0000, 1'b0, 4, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h0000, 1'b1, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    // one more tick closes the interval on the next block end
    add_row(ROW_WORD, bpam_pkg::OP_TICK, 16'h0000, 1'b0, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'hFFFF, 1'b1, 1, 1'b0, 1'b0, 16'd0, 16'd0);
    // interval zero: any block end after one tick reports
    add_row(ROW_SET_INTERVAL, bpam_pkg::OP_SAMPLE, 16'd0, 1'b0, 1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'hFFFF, 1'b1, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_TICK, 16'hFFFF, 1'b1, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h0005, 1'b1, 1, 1'b1, 1'b1, 16'd3, 16'd2);
    // after a report the timer stays running from zero
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h0007, 1'b1, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_TICK, 16'h0000, 1'b0, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h0000, 1'b1, 1, 1'b1, 1'b1, 16'd3, 16'd2);
    // widest interval: a few ticks are far from enough, -32767 gives peak 32767
    add_row(ROW_SET_INTERVAL, bpam_pkg::OP_SAMPLE, 16'hFFFF, 1'b0, 1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_TICK, 16'h0000, 1'b0, 3, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'd100, 1'b0, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h8001, 1'b1, 1, 1'b1, 1'b0, 16'd0, 16'd0);
    // shrinking the interval lets the next block end report
    add_row(ROW_SET_INTERVAL, bpam_pkg::OP_SAMPLE, 16'd1, 1'b0, 1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_row(ROW_WORD, bpam_pkg::OP_SAMPLE, 16'h8000, 1'b1, 1, 1'b1, 1'b1, 16'd32767, 16'd2);

    // hold reset from the start, then release it at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_interval_reg();

    // walk the table; repeated rows stream back to back
    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      if (row.kind == ROW_SET_INTERVAL) begin
        set_interval(row.value);
      end else begin
        for (int i = 0; i < int'(row.reps); i++)
          send_word(row.op, row.value, row.blk_end, row.reps > 1, row.typed,
                    row.exp_hit, row.exp_rep);
      end
    end

    // random part: well-formed blocks of 1..6 samples with ticks sprinkled between,
    // each phase at a new interval (mostly short so averages come often)
    n_rand = 0;
    phase_left = 0;
    while (n_rand < RAND_WORDS) begin
      if (phase_left <= 0) begin
        case ($urandom_range(0, 5))
          0: iv = '0;
          1: iv = '1;
          2: iv = bpam_pkg::INTERVAL_RESET;
          default: iv = bpam_pkg::INTERVAL_W'($urandom_range(1, 12));
        endcase
        set_interval(iv);
        phase_left = $urandom_range(60, 150);
      end
      blk_len = $urandom_range(1, 6);
      for (int k = 0; k < int'(blk_len); k++) begin
        // ticks carry junk in the ignored fields
        while ($urandom_range(0, 9) < 4) begin
          send_word(bpam_pkg::OP_TICK, 16'($urandom), 1'($urandom), 1'b0, 1'b0, 1'b0,
                    no_rep);
          n_rand++;
          phase_left--;
        end
        case ($urandom_range(0, 7))
          0: smp = 16'h8000;
          1: smp = 16'h7FFF;
          2: smp = 16'h0000;
          3: smp = 16'hFFFF;
          default: smp = 16'($urandom);
        endcase
        send_word(bpam_pkg::OP_SAMPLE, smp, k == int'(blk_len) - 1, 1'b0, 1'b0, 1'b0,
                  no_rep);
        n_rand++;
        phase_left--;
      end
    end

    drain_results();
    $display("tb_top: %0d words sent, %0d of %0d averages checked, %0d interval settings",
             n_words, n_averages_checked, n_averages_expected, n_settings);
    $display("tb_top: covered ignored ticks, sample extremes, back to back words, interval 0/1/max");
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
